### rtl/core/rmsm_pkg.sv
// ----------------------------------------------------------------------------
// rmsm_pkg
// shared types and constants of the block rms presence meter
// ----------------------------------------------------------------------------
package rmsm_pkg;

	// field widths of a result beat
	localparam int LEVEL_W = 16;
	localparam int MIN_W   = 15;
	localparam int MAX_W   = 16;
	localparam int RATIO_W = 16;

	// configuration register widths and reset values
	localparam int BL_W  = 13;
	localparam int BPT_W = 10;
	localparam logic [BL_W-1:0]  BLOCK_LENGTH_RESET    = 13'd1600;
	localparam logic [BPT_W-1:0] BLOCKS_PER_TEST_RESET = 10'd100;

	// register word index (paddr bit 2)
	localparam logic REG_BLOCK_LENGTH    = 1'b0;
	localparam logic REG_BLOCKS_PER_TEST = 1'b1;

	// smallest level restarts at full scale
	localparam logic [MIN_W-1:0] LOW_RESET = 15'h7fff;

	// block mean square saturates here
	localparam int MEAN_W = 31;
	localparam logic [MEAN_W-1:0] MEAN_CAP = 31'h4000_0000;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_FINISH = 1'b1
	} kind_e_t;

	typedef enum logic [1:0] {
		VERDICT_NONE    = 2'd0,
		VERDICT_SILENCE = 2'd1,
		VERDICT_WORKING = 2'd2,
		VERDICT_NOISE   = 2'd3
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_UPD,
		ST_VERD,
		ST_RATIO,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		verdict_t           verdict;
		logic [MAX_W-1:0]   max_level;
		logic [MIN_W-1:0]   min_level;
		logic [LEVEL_W-1:0] level;
		logic               is_final;
	} result_t;

endpackage

### rtl/core/rmsm_fifo.sv
// ----------------------------------------------------------------------------
// rmsm_fifo
// short register queue between front and back, depth a power of two
// ----------------------------------------------------------------------------
module rmsm_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/rmsm_front.sv
// ----------------------------------------------------------------------------
// rmsm_front
// squares samples, accumulates the block sum, queues block ends and finishes
// ----------------------------------------------------------------------------
module rmsm_front #(
	parameter int MAX_BLOCK_LENGTH = 4096,
	parameter int LW               = 13,
	parameter int SW               = 43
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic signed [15:0]       sample,
	input  logic [rmsm_pkg::BL_W-1:0] block_length,
	input  logic                     q_full,
	output logic                     q_push,
	output logic [SW+LW:0]           q_data
);

	import rmsm_pkg::*;

	logic                 valid_s1;
	kind_e_t              kind_s1;
	logic [MEAN_W-1:0]    sq_s1;
	logic [SW-1:0]        sum_q;
	logic [LW-1:0]        cnt_q;

	logic signed [31:0]   prod;
	logic [31:0]          bl_wide;
	logic [LW-1:0]        eff_len;
	logic [SW-1:0]        sum_next;
	logic [LW-1:0]        cnt_next;
	logic                 block_end;
	logic                 advance;

	assign prod    = sample * sample;
	assign bl_wide = 32'(block_length);

	always_comb begin
		if (bl_wide == 32'd0) begin
			eff_len = LW'(1);
		end else if (bl_wide > 32'(MAX_BLOCK_LENGTH)) begin
			eff_len = LW'(MAX_BLOCK_LENGTH);
		end else begin
			eff_len = LW'(bl_wide);
		end
	end

	assign sum_next  = sum_q + SW'(sq_s1);
	assign cnt_next  = cnt_q + 1'b1;
	assign block_end = (cnt_next >= eff_len);

	assign q_push   = valid_s1 && !q_full && ((kind_s1 == KIND_FINISH) || block_end);
	assign advance  = !valid_s1 || (kind_s1 == KIND_SAMPLE && !block_end) || !q_full;
	assign in_ready = advance;
	assign q_data   = {kind_s1, eff_len, sum_next};

	// square stage
	always_ff @(posedge clk) begin
		if (in_valid && advance) begin
			sq_s1 <= prod[MEAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= KIND_SAMPLE;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (advance) begin
				valid_s1 <= in_valid;
				if (in_valid) begin
					kind_s1 <= kind_e_t'(req_type);
				end
			end
			// accumulate, or clear on block end and on finish
			if (valid_s1 && advance) begin
				if (kind_s1 == KIND_FINISH || block_end) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
		end
	end

endmodule

### rtl/core/rmsm_div.sv
// ----------------------------------------------------------------------------
// rmsm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rmsm_div #(
	parameter int NW = 43,
	parameter int DW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   div_q;

	logic [DW:0]     trial;
	logic [DW:0]     diff;
	logic            ge;

	assign trial    = {rem_q, quo_q[NW-1]};
	assign diff     = trial - {1'b0, div_q};
	assign ge       = (trial >= {1'b0, div_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

### rtl/core/rmsm_back.sv
// ----------------------------------------------------------------------------
// rmsm_back
// per block: mean by division, level by square root, min/max; per test: ratio, verdict
// ----------------------------------------------------------------------------
module rmsm_back #(
	parameter int LW = 13,
	parameter int SW = 43
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  logic [SW+LW:0]              q_data,
	output logic                        q_pop,
	input  logic [rmsm_pkg::BPT_W-1:0]  blocks_per_test,
	output logic                        res_valid,
	input  logic                        res_ready,
	output rmsm_pkg::result_t           res
);

	import rmsm_pkg::*;

	localparam int DW = (LW > MIN_W) ? LW : MIN_W;

	back_state_t       state_q;
	back_state_t       state_d;

	logic [LEVEL_W-1:0] level_q;
	logic [MIN_W-1:0]   low_q;
	logic [MAX_W-1:0]   high_q;
	logic [BPT_W-1:0]   bc_q;
	logic               final_q;
	logic [MEAN_W-1:0]  v_q;
	logic [MEAN_W-1:0]  root_q;
	logic [MEAN_W-1:0]  bit_q;
	result_t            res_q;

	kind_e_t            head_kind;
	logic [LW-1:0]      head_len;
	logic [SW-1:0]      head_sum;

	logic               div_start;
	logic [SW-1:0]      div_num;
	logic [DW-1:0]      div_den;
	logic               div_done;
	logic [SW-1:0]      div_quo;

	logic [MEAN_W:0]    sq_trial;
	logic               sq_ge;
	logic [LEVEL_W-1:0] lvl;
	logic [BPT_W-1:0]   bpt_eff;
	logic [BPT_W-1:0]   bc_next;
	logic [MAX_W:0]     low3;
	logic               working;

	assign head_sum  = q_data[SW-1:0];
	assign head_len  = q_data[SW+LW-1:SW];
	assign head_kind = kind_e_t'(q_data[SW+LW]);

	assign sq_trial = {1'b0, root_q} + {1'b0, bit_q};
	assign sq_ge    = ({1'b0, v_q} >= sq_trial);
	assign lvl      = root_q[LEVEL_W-1:0];
	assign bpt_eff  = (blocks_per_test == '0) ? BPT_W'(1) : blocks_per_test;
	assign bc_next  = bc_q + 1'b1;
	assign low3     = (MAX_W+1)'(low_q) + {1'b0, low_q, 1'b0};
	assign working  = (low_q != '0) && ({1'b0, high_q} > low3);

	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;

	rmsm_div #(
		.NW (SW),
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = SW'(high_q);
		div_den   = DW'(low_q);
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (head_kind == KIND_FINISH) begin
						state_d = ST_VERD;
					end else begin
						div_start = 1'b1;
						div_num   = head_sum;
						div_den   = DW'(head_len);
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (bit_q[0]) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = ST_VERD;
			end
			ST_VERD: begin
				if (final_q && high_q != '0 && working) begin
					div_start = 1'b1;
					state_d   = ST_RATIO;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_RATIO: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath without reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				level_q <= '0;
			end
			ST_DIV: begin
				if (div_done) begin
					v_q    <= (div_quo > SW'(MEAN_CAP)) ? MEAN_CAP : div_quo[MEAN_W-1:0];
					root_q <= '0;
					bit_q  <= MEAN_CAP;
				end
			end
			ST_SQRT: begin
				if (sq_ge) begin
					v_q    <= v_q - sq_trial[MEAN_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_UPD: begin
				level_q <= lvl;
			end
			ST_VERD: begin
				res_q.level     <= level_q;
				res_q.min_level <= low_q;
				res_q.max_level <= high_q;
				res_q.is_final  <= final_q;
				res_q.ratio     <= '0;
				if (!final_q) begin
					res_q.verdict <= VERDICT_NONE;
				end else if (high_q == '0) begin
					res_q.verdict <= VERDICT_SILENCE;
				end else if (working) begin
					res_q.verdict <= VERDICT_WORKING;
				end else begin
					res_q.verdict <= VERDICT_NOISE;
				end
			end
			ST_RATIO: begin
				if (div_done) begin
					res_q.ratio <= div_quo[RATIO_W-1:0];
				end
			end
			default: begin
				level_q <= level_q;
			end
		endcase
	end

	// test state: min, max, block count; restarts after a final result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= LOW_RESET;
			high_q  <= '0;
			bc_q    <= '0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					final_q <= !q_empty && (head_kind == KIND_FINISH);
				end
				ST_UPD: begin
					if ({1'b0, lvl} < (LEVEL_W+1)'(low_q)) begin
						low_q <= lvl[MIN_W-1:0];
					end
					if (lvl > high_q) begin
						high_q <= lvl;
					end
					bc_q    <= bc_next;
					final_q <= (bc_next >= bpt_eff);
				end
				ST_OUT: begin
					if (res_ready && final_q) begin
						low_q  <= LOW_RESET;
						high_q <= '0;
						bc_q   <= '0;
					end
				end
				default: begin
					final_q <= final_q;
				end
			endcase
		end
	end

endmodule

### rtl/core/audio_rms_presence_meter_unit.sv
// ----------------------------------------------------------------------------
// audio_rms_presence_meter_unit
// block rms level meter with min/max tracking and a presence verdict
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one beat per sample or finish request (s_tuser high = finish
//   now, partial block dropped). m_ channel: one beat per completed block and
//   one per finish; m_tlast marks the beat that ends a test and carries the
//   verdict (and ratio when the mic is judged working).
//   apb port: block_length at 0x0, blocks_per_test at 0x4, write only while
//   the block is idle.
// timing:
//   samples are taken one per cycle while s_tready is high; the front squares
//   (a registered stage) and sums, and pushes each block end or finish into
//   a 4-entry queue. per block the back runs the restoring divider over the
//   SW-bit sum for the mean (SW = sum width, 43 at the default
//   MAX_BLOCK_LENGTH), then the square root, then bookkeeping; a working final
//   verdict runs the divider, shared with the mean, once more for the ratio.
//   the back takes a new block only when done with the last, so very short
//   blocks back up the queue and s_tready drops until the back catches up.
// reset: registers return to 1600 / 100, test state clears, no beat pending.
// stall: a held result stays on m_tdata; the front keeps taking samples and
//   the queue block ends until the queue is full.
// ----------------------------------------------------------------------------
module audio_rms_presence_meter_unit #(
	parameter int MAX_BLOCK_LENGTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] sample (signed)
	input  logic        s_tuser,  // [0] req_type (1 = finish test)
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [15:0] level, [30:16] min_level, [46:31] max_level,
	                              // [48:47] verdict, [64:49] ratio, [71:65] zero
	output logic        m_tlast,  // is_final
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import rmsm_pkg::*;

	localparam int LW     = $clog2(MAX_BLOCK_LENGTH + 1);
	localparam int SW     = 31 + $clog2(MAX_BLOCK_LENGTH);
	localparam int FW     = SW + LW + 1;
	localparam int QDEPTH = 4;

	logic [BL_W-1:0]  block_length_q;
	logic [BPT_W-1:0] blocks_per_test_q;

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	logic [FW-1:0]    q_wdata;
	logic [FW-1:0]    q_rdata;
	result_t          res;

	// configuration registers, word chosen by paddr bit 2
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q    <= BLOCK_LENGTH_RESET;
			blocks_per_test_q <= BLOCKS_PER_TEST_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_BLOCK_LENGTH:    block_length_q    <= pwdata[BL_W-1:0];
				REG_BLOCKS_PER_TEST: blocks_per_test_q <= pwdata[BPT_W-1:0];
				default:             block_length_q    <= block_length_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BLOCK_LENGTH:    prdata = 32'(block_length_q);
			REG_BLOCKS_PER_TEST: prdata = 32'(blocks_per_test_q);
			default:             prdata = '0;
		endcase
	end

	// front: square and accumulate
	rmsm_front #(
		.MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH),
		.LW               (LW),
		.SW               (SW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.req_type     (s_tuser),
		.sample       (s_tdata),
		.block_length (block_length_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	// queue of block sums and finish requests
	rmsm_fifo #(
		.W     (FW),
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: mean, root, min/max, verdict; holds the result beat
	rmsm_back #(
		.LW (LW),
		.SW (SW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (q_rdata),
		.q_pop           (q_pop),
		.blocks_per_test (blocks_per_test_q),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.res             (res)
	);

	assign m_tdata = {7'b0, res.ratio, res.verdict, res.max_level, res.min_level, res.level};
	assign m_tlast = res.is_final;

	// a block beat carries no verdict and no ratio
	a_block_no_verdict : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> res.verdict == VERDICT_NONE && res.ratio == '0)
		else $error("verdict or ratio on a non-final beat");

	// a final beat always carries a verdict
	a_final_has_verdict : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> res.verdict != VERDICT_NONE)
		else $error("final beat without verdict");

	// a block level lies between the running min and max
	a_level_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |->
			res.level <= res.max_level && (LEVEL_W)'(res.min_level) <= res.level)
		else $error("block level outside min/max");

	// ratio only with a working verdict
	a_ratio_working : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.verdict != VERDICT_WORKING |-> res.ratio == '0)
		else $error("ratio without working verdict");

	// queue never both full and empty
	a_queue_sane : assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty at once");

endmodule
